// ----- sv/rdfe_pkg.sv -----
// ----------------------------------------------------------------------------
// rdfe_pkg
// Shared types and constants of the raster draw and flood fill engine.
// ----------------------------------------------------------------------------
package rdfe_pkg;

    localparam int COORD_W = 9;
    localparam int COLOR_W = 8;

    localparam logic [COLOR_W-1:0] CLEAR_COLOR = 8'd79;

    localparam logic [2:0] KIND_CLEAR = 3'd0;
    localparam logic [2:0] KIND_PIXEL = 3'd1;
    localparam logic [2:0] KIND_VLINE = 3'd2;
    localparam logic [2:0] KIND_HLINE = 3'd3;
    localparam logic [2:0] KIND_RECT  = 3'd4;
    localparam logic [2:0] KIND_FLOOD = 3'd5;
    localparam logic [2:0] KIND_READ  = 3'd6;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [2:0]         kind;
        logic [COORD_W-1:0] x_first;
        logic [COORD_W-1:0] y_first;
        logic [COORD_W-1:0] x_second;
        logic [COORD_W-1:0] y_second;
        logic [COLOR_W-1:0] color;
    } t_cmd;

    typedef struct packed {
        logic [COLOR_W-1:0] pixel_color;
        logic               out_of_area;
    } t_result;

endpackage

// ----- sv/raster_draw_flood_fill_engine_core.sv -----
// ----------------------------------------------------------------------------
// raster_draw_flood_fill_engine_core
// Canvas editor: clear, pixel, lines, rectangle, 4-way flood fill and read.
// ----------------------------------------------------------------------------
// Usage:
// A command transaction is taken on a rising edge where start is high and
// busy is low; busy then stays high until the command is finished, unless
// it finishes at once. Every command gives exactly one result transaction:
// o_result_valid is high for one cycle with o_result, and the receiver must
// take it then. Drawing commands walk the clipped pixel area with one memory
// write per cycle. A command that draws nothing finishes at once, without
// making busy high. A read passes through an address state and a fetch
// state. Flood fill reads the seed, then for each recolored pixel pops it
// from the stack and checks each of its four neighbors inside the area
// against the seed's old color on the canvas memory port; each matching
// neighbor is recolored and pushed onto the stack.
// Only one command is in flight at a time.
// Reset clears the sequencer and the stack count and sets both size
// registers to 256; the canvas holds no defined value until written, so a
// clear must come before the first read. The user must write size registers
// on the configuration port only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module raster_draw_flood_fill_engine_core #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  rdfe_pkg::t_cmd   i_cmd,
    output logic             busy,
    output logic             o_result_valid,
    output rdfe_pkg::t_result o_result,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [8:0]       i_cfg_data
);
    import rdfe_pkg::*;

    localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int SCW   = $clog2(CELLS + 1);
    localparam int SW    = 2 * COORD_W;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DRAW,
        ST_RD_ADDR,
        ST_RD_GET,
        ST_FL_ADDR,
        ST_FL_SEED,
        ST_FL_POP,
        ST_FL_POPW,
        ST_FL_NB,
        ST_FL_NADDR,
        ST_FL_NCHK
    } t_state;

    t_state             r_state;
    logic [8:0]         r_width;
    logic [8:0]         r_height;
    logic [COORD_W-1:0] r_cx, r_cy;     // current cell, zero based
    logic [COORD_W-1:0] r_xlo, r_xhi, r_yhi;
    logic [COORD_W-1:0] r_px, r_py;     // popped cell
    logic [1:0]         r_nb;
    logic [COLOR_W-1:0] r_color;
    logic [COLOR_W-1:0] r_old;
    logic [SCW-1:0]     r_cnt;
    logic               r_done;
    t_result            r_res;

    // Effective area, with zero acting as one and large values clamped.
    logic [COORD_W-1:0] w_cols, w_rows;
    assign w_cols = (r_width == '0) ? COORD_W'(1) :
                    ((int'(r_width) > MAX_WIDTH) ? COORD_W'(MAX_WIDTH) : r_width);
    assign w_rows = (r_height == '0) ? COORD_W'(1) :
                    ((int'(r_height) > MAX_HEIGHT) ? COORD_W'(MAX_HEIGHT) : r_height);

    logic w_x1_ok, w_y1_ok, w_x2_ok, w_y2_ok;
    assign w_x1_ok = (i_cmd.x_first  != '0) && (i_cmd.x_first  <= w_cols);
    assign w_y1_ok = (i_cmd.y_first  != '0) && (i_cmd.y_first  <= w_rows);
    assign w_x2_ok = (i_cmd.x_second != '0) && (i_cmd.x_second <= w_cols);
    assign w_y2_ok = (i_cmd.y_second != '0) && (i_cmd.y_second <= w_rows);

    // Span of a drawing command before clipping, one based.
    logic [COORD_W-1:0] w_xa, w_xb, w_ya, w_yb;
    logic               w_rev;
    logic               w_oob;
    always_comb begin
        w_xa  = i_cmd.x_first;
        w_xb  = i_cmd.x_first;
        w_ya  = i_cmd.y_first;
        w_yb  = i_cmd.y_first;
        w_rev = 1'b0;
        w_oob = 1'b0;
        case (i_cmd.kind)
            KIND_CLEAR: begin
                w_xa = COORD_W'(1);
                w_xb = w_cols;
                w_ya = COORD_W'(1);
                w_yb = w_rows;
            end
            KIND_PIXEL: begin
                w_oob = !(w_x1_ok && w_y1_ok);
            end
            KIND_VLINE: begin
                w_oob = !(w_x1_ok && w_y1_ok && w_y2_ok);
                if (i_cmd.y_first > i_cmd.y_second) begin
                    w_ya = i_cmd.y_second;
                end else begin
                    w_yb = i_cmd.y_second;
                end
            end
            KIND_HLINE: begin
                w_oob = !(w_x1_ok && w_x2_ok && w_y1_ok);
                if (i_cmd.x_first > i_cmd.x_second) begin
                    w_xa = i_cmd.x_second;
                end else begin
                    w_xb = i_cmd.x_second;
                end
            end
            KIND_RECT: begin
                w_oob = !(w_x1_ok && w_x2_ok && w_y1_ok && w_y2_ok);
                w_xb  = i_cmd.x_second;
                w_yb  = i_cmd.y_second;
                w_rev = (i_cmd.x_first > i_cmd.x_second) ||
                        (i_cmd.y_first > i_cmd.y_second);
            end
            KIND_FLOOD, KIND_READ: begin
                w_oob = !(w_x1_ok && w_y1_ok);
            end
            default: begin
                w_oob = 1'b0;
            end
        endcase
    end

    // Clip the span to the area; an empty span draws nothing.
    logic [COORD_W-1:0] w_xl, w_xh, w_yl, w_yh;
    logic               w_empty;
    assign w_xl    = (w_xa == '0) ? COORD_W'(1) : w_xa;
    assign w_yl    = (w_ya == '0) ? COORD_W'(1) : w_ya;
    assign w_xh    = (w_xb > w_cols) ? w_cols : w_xb;
    assign w_yh    = (w_yb > w_rows) ? w_rows : w_yb;
    assign w_empty = w_rev || (w_xl > w_xh) || (w_yl > w_yh);

    // Neighbor of the popped cell: up, left, right, down.
    logic [COORD_W-1:0] w_nx, w_ny;
    logic               w_nok;
    always_comb begin
        w_nx  = r_px;
        w_ny  = r_py;
        w_nok = 1'b0;
        case (r_nb)
            2'd0: begin
                w_ny  = r_py - 1'b1;
                w_nok = (r_py != '0);
            end
            2'd1: begin
                w_nx  = r_px - 1'b1;
                w_nok = (r_px != '0);
            end
            2'd2: begin
                w_nx  = r_px + 1'b1;
                w_nok = ({1'b0, r_px} + 1'b1) < {1'b0, w_cols};
            end
            default: begin
                w_ny  = r_py + 1'b1;
                w_nok = ({1'b0, r_py} + 1'b1) < {1'b0, w_rows};
            end
        endcase
    end

    // Canvas port: the address always follows the current cell.
    logic [AW-1:0]      w_caddr;
    logic               w_cwe;
    logic [COLOR_W-1:0] w_crd;
    assign w_caddr = AW'(int'(r_cy) * MAX_WIDTH + int'(r_cx));

    // Stack port.
    logic [SCW-1:0] w_cnt_m1;
    logic [AW-1:0]  w_saddr;
    logic           w_swe;
    logic [SW-1:0]  w_srd;
    assign w_cnt_m1 = r_cnt - 1'b1;

    logic w_match;
    assign w_match = (w_crd == r_old);

    always_comb begin
        w_cwe   = 1'b0;
        w_swe   = 1'b0;
        w_saddr = r_cnt[AW-1:0];
        case (r_state)
            ST_DRAW: begin
                w_cwe = 1'b1;
            end
            ST_FL_SEED: begin
                w_cwe = (w_crd != r_color);
                w_swe = (w_crd != r_color);
            end
            ST_FL_NCHK: begin
                w_cwe = w_match;
                w_swe = w_match;
            end
            ST_FL_POP: begin
                w_saddr = w_cnt_m1[AW-1:0];
            end
            default: begin
                w_cwe = 1'b0;
            end
        endcase
    end

    rdfe_ram #(.DEPTH(CELLS), .WIDTH(COLOR_W)) u_canvas (
        .i_clk   (i_clk),
        .i_we    (w_cwe),
        .i_addr  (w_caddr),
        .i_wdata (r_color),
        .o_rdata (w_crd)
    );

    rdfe_ram #(.DEPTH(CELLS), .WIDTH(SW)) u_stack (
        .i_clk   (i_clk),
        .i_we    (w_swe),
        .i_addr  (w_saddr),
        .i_wdata ({r_cy, r_cx}),
        .o_rdata (w_srd)
    );

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 9'd256;
            r_height <= 9'd256;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_WIDTH) begin
                r_width <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_HEIGHT) begin
                r_height <= i_cfg_data;
            end
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
            r_cnt   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_color <= i_cmd.color;
                        r_res   <= '{pixel_color: '0, out_of_area: w_oob};
                        r_cx    <= i_cmd.x_first - 1'b1;
                        r_cy    <= i_cmd.y_first - 1'b1;
                        r_xlo   <= w_xl - 1'b1;
                        r_xhi   <= w_xh - 1'b1;
                        r_yhi   <= w_yh - 1'b1;
                        case (i_cmd.kind)
                            KIND_CLEAR, KIND_PIXEL, KIND_VLINE, KIND_HLINE,
                            KIND_RECT: begin
                                r_cx <= w_xl - 1'b1;
                                r_cy <= w_yl - 1'b1;
                                if (i_cmd.kind == KIND_CLEAR) begin
                                    r_color <= CLEAR_COLOR;
                                end
                                if (w_empty) begin
                                    r_done <= 1'b1;
                                end else begin
                                    r_state <= ST_DRAW;
                                end
                            end
                            KIND_READ: begin
                                if (w_oob) begin
                                    r_done <= 1'b1;
                                end else begin
                                    r_state <= ST_RD_ADDR;
                                end
                            end
                            KIND_FLOOD: begin
                                if (w_oob) begin
                                    r_done <= 1'b1;
                                end else begin
                                    r_state <= ST_FL_ADDR;
                                end
                            end
                            default: begin
                                r_done <= 1'b1;
                            end
                        endcase
                    end
                end
                ST_DRAW: begin
                    if (r_cx == r_xhi) begin
                        r_cx <= r_xlo;
                        if (r_cy == r_yhi) begin
                            r_done  <= 1'b1;
                            r_state <= ST_IDLE;
                        end else begin
                            r_cy <= r_cy + 1'b1;
                        end
                    end else begin
                        r_cx <= r_cx + 1'b1;
                    end
                end
                ST_RD_ADDR: begin
                    r_state <= ST_RD_GET;
                end
                ST_RD_GET: begin
                    r_res.pixel_color <= w_crd;
                    r_done            <= 1'b1;
                    r_state           <= ST_IDLE;
                end
                ST_FL_ADDR: begin
                    r_state <= ST_FL_SEED;
                end
                ST_FL_SEED: begin
                    r_old <= w_crd;
                    if (w_crd == r_color) begin
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_cnt   <= SCW'(1);
                        r_state <= ST_FL_POP;
                    end
                end
                ST_FL_POP: begin
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= ST_IDLE;
                    end else begin
                        r_cnt   <= w_cnt_m1;
                        r_state <= ST_FL_POPW;
                    end
                end
                ST_FL_POPW: begin
                    r_py    <= w_srd[SW-1:COORD_W];
                    r_px    <= w_srd[COORD_W-1:0];
                    r_nb    <= 2'd0;
                    r_state <= ST_FL_NB;
                end
                ST_FL_NB: begin
                    if (w_nok) begin
                        r_cx    <= w_nx;
                        r_cy    <= w_ny;
                        r_state <= ST_FL_NADDR;
                    end else if (r_nb == 2'd3) begin
                        r_state <= ST_FL_POP;
                    end else begin
                        r_nb <= r_nb + 1'b1;
                    end
                end
                ST_FL_NADDR: begin
                    r_state <= ST_FL_NCHK;
                end
                ST_FL_NCHK: begin
                    if (w_match) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_nb == 2'd3) begin
                        r_state <= ST_FL_POP;
                    end else begin
                        r_nb    <= r_nb + 1'b1;
                        r_state <= ST_FL_NB;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_result_valid = r_done;
    assign o_result       = r_res;

endmodule

// ----- sv/rdfe_ram.sv -----
// ----------------------------------------------------------------------------
// rdfe_ram
// Single-port memory; each cycle reads and may write; read data is registered.
// ----------------------------------------------------------------------------
module rdfe_ram #(
    parameter int DEPTH = 65536,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/rdfe_checker.sv -----
// ----------------------------------------------------------------------------
// rdfe_checker
// Port-level checks of the command and result transactions.
// ----------------------------------------------------------------------------
module rdfe_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_result_valid
);

    // Without a new command, a result strobe is not held high.
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !start) |=> !o_result_valid)
        else $error("result strobe held for two cycles");

    // An accepted command makes the block busy or finishes at once.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_result_valid))
        else $error("accepted command neither busy nor finished");

    // A result comes out only as the block returns to idle.
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobe while busy");

    // Busy falls only together with a result.
    a_fall_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_result_valid)
        else $error("command ended without a result");

    // Reset leaves the block idle with no result.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!busy && !o_result_valid))
        else $error("block not idle after reset");

endmodule

bind raster_draw_flood_fill_engine_core rdfe_checker u_rdfe_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid)
);
